@@ sv/dtc_pkg.sv @@
// Shared types and constants for the dense-to-CSR threshold compactor.
package dtc_pkg;

   localparam longint unsigned MaxColumns = 64'd65536;
   localparam logic [15:0] ColCap =
      (MaxColumns - 64'd1 > 64'd65535) ? 16'hFFFF : 16'(MaxColumns - 64'd1);

   localparam logic [31:0] MagMask    = 32'h7FFF_FFFF;
   localparam logic [31:0] ExpAllOnes = 32'h7F80_0000;
   localparam logic [31:0] KeptMax    = 32'hFFFF_FFFF;

   localparam int unsigned ResultDepth = 4;

   localparam logic KIND_ENTRY = 1'b0;
   localparam logic KIND_ROW   = 1'b1;

   typedef struct packed {
      logic [31:0] element_bits;
      logic        row_end;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [15:0] column_index;
      logic [31:0] value_bits;
      logic [31:0] row_offset;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic    entry_vld;
      logic    row_vld;
      rsp_type entry;
      rsp_type row;
   } push_type;

endpackage

@@ sv/dtc_engine.sv @@
// Keep test, column and kept-count tracking, threshold register.
module dtc_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr,
   input  logic [31:0]      csr_wdata,
   input  logic             advance,
   input  dtc_pkg::req_type item,
   output dtc_pkg::push_type push
);
   import dtc_pkg::*;

   logic [31:0] thr_ff;
   logic [31:0] thr_in;
   logic [15:0] col_ff;
   logic [15:0] col_in;
   logic [31:0] kept_ff;
   logic [31:0] kept_in;

   logic [31:0] mag;
   logic [31:0] thr_mag;
   logic        is_nan;
   logic        keep;
   logic [15:0] col;
   logic [31:0] kept_new;

   always_comb begin
      mag      = item.element_bits & MagMask;
      thr_mag  = thr_ff & MagMask;
      is_nan   = (mag > ExpAllOnes) || (thr_mag > ExpAllOnes);
      keep     = !is_nan && (thr_ff[31] || (mag >= thr_mag));
      col      = (col_ff > ColCap) ? ColCap : col_ff;
      kept_new = (keep && (kept_ff != KeptMax)) ? kept_ff + 32'd1 : kept_ff;

      push.entry_vld          = advance & keep;
      push.row_vld            = advance & item.row_end;
      push.entry.result_kind  = KIND_ENTRY;
      push.entry.column_index = col;
      push.entry.value_bits   = item.element_bits;
      push.entry.row_offset   = kept_new;
      push.entry.last_of_run  = ~item.row_end;
      push.row.result_kind    = KIND_ROW;
      push.row.column_index   = '0;
      push.row.value_bits     = '0;
      push.row.row_offset     = kept_new;
      push.row.last_of_run    = 1'b1;

      thr_in  = csr_wr ? csr_wdata : thr_ff;
      kept_in = kept_ff;
      col_in  = col_ff;
      if (advance) begin
         kept_in = kept_new;
         if (item.row_end) begin
            col_in = '0;
         end else if (col < ColCap) begin
            col_in = col + 16'd1;
         end else begin
            col_in = ColCap;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= '0;
         col_ff  <= '0;
         kept_ff <= '0;
      end else begin
         thr_ff  <= thr_in;
         col_ff  <= col_in;
         kept_ff <= kept_in;
      end
   end

endmodule

@@ sv/dtc_result_queue.sv @@
// Result queue: takes up to two results a cycle, hands out one while rsp_stall is low.
module dtc_result_queue #(
   parameter int unsigned DEPTH = dtc_pkg::ResultDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  dtc_pkg::push_type push,
   output logic              room,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dtc_pkg::rsp_type  rsp_data
);
   import dtc_pkg::*;

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

   rsp_type         mem_ff [DEPTH];
   logic [PtrW-1:0] wptr_ff;
   logic [PtrW-1:0] wptr_in;
   logic [PtrW-1:0] rptr_ff;
   logic [PtrW-1:0] rptr_in;
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;

   logic [PtrW-1:0] wptr1;
   logic [PtrW-1:0] wptr2;
   logic [PtrW-1:0] row_ptr;
   logic [1:0]      n_push;
   logic            pop;

   always_comb begin
      wptr1    = (wptr_ff == PtrLast) ? '0 : wptr_ff + PtrW'(1);
      wptr2    = (wptr1 == PtrLast) ? '0 : wptr1 + PtrW'(1);
      row_ptr  = push.entry_vld ? wptr1 : wptr_ff;
      n_push   = {1'b0, push.entry_vld} + {1'b0, push.row_vld};
      pop      = (count_ff != '0) && !rsp_stall;
      count_in = CntW'(count_ff + CntW'(n_push) - CntW'(pop));
      case (n_push)
         2'd1:    wptr_in = wptr1;
         2'd2:    wptr_in = wptr2;
         default: wptr_in = wptr_ff;
      endcase
      rptr_in   = pop ? ((rptr_ff == PtrLast) ? '0 : rptr_ff + PtrW'(1)) : rptr_ff;
      room      = count_ff <= CntW'(DEPTH - 2);
      rsp_valid = count_ff != '0;
      rsp_data  = mem_ff[rptr_ff];
   end

   always_ff @(posedge clock) begin
      if (push.entry_vld) begin
         mem_ff[wptr_ff] <= push.entry;
      end
      if (push.row_vld) begin
         mem_ff[row_ptr] <= push.row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ sv/dense_to_csr_threshold_compactor.sv @@
// Top level of the dense-to-CSR threshold compactor.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_data  (element_bits, row_end)
//   rsp      out        rsp_valid / rsp_stall  rsp_data  (kind, column, value, offset, last)
//   csr      in         csr_valid / csr_ready  csr_wdata (threshold_bits)
//
// One request a cycle enters the input register while req_stall is low; it is classified
// once the queue has room, and its zero, one or two results are registered in the result queue.
// Sustained rate is one request per cycle while requests give at most one result and rsp_stall
// stays low; the single-result output port holds the input back for a kept row end.
// Reset is synchronous and clears the threshold, column counter, kept count and queue.
// req_stall rises only when the input register is full and the queue lacks room for two.
module dense_to_csr_threshold_compactor #(
   parameter int unsigned RESULT_DEPTH = dtc_pkg::ResultDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dtc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dtc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [31:0]      csr_wdata
);
   import dtc_pkg::*;

   req_type  in_ff;
   req_type  in_in;
   logic     in_vld_ff;
   logic     in_vld_in;
   logic     room;
   logic     advance;
   logic     accept;
   push_type push;

   always_comb begin
      csr_ready = 1'b1;
      advance   = in_vld_ff & room;
      req_stall = in_vld_ff & ~room;
      accept    = req_valid & ~req_stall;
      in_in     = accept ? req_data : in_ff;
      in_vld_in = accept | (in_vld_ff & ~advance);
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   dtc_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_wr    (csr_valid & csr_ready),
      .csr_wdata (csr_wdata),
      .advance   (advance),
      .item      (in_ff),
      .push      (push)
   );

   dtc_result_queue #(
      .DEPTH (RESULT_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ sv/dtc_checker.sv @@
// Port-level checks for the dense-to-CSR threshold compactor, bound to the top level.
module dtc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input dtc_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input dtc_pkg::rsp_type rsp_data,
   input logic             csr_valid,
   input logic             csr_ready
);
   import dtc_pkg::*;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_row_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.result_kind == KIND_ENTRY
         && !rsp_data.last_of_run
      |=> rsp_valid && rsp_data.result_kind == KIND_ROW
         && rsp_data.row_offset == $past(rsp_data.row_offset))
      else $error("entry on a row end not followed by its row offset");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("threshold write refused");

endmodule

bind dense_to_csr_threshold_compactor dtc_checker u_chk (.*);
